[rtl/core/nihs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nihs_pkg: shared definitions for the nearest index hunt search
// Operation codes, walk states and default sizes.
// ----------------------------------------------------------------------------

package nihs_pkg;

  // Default table geometry
  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefValueWidth = 32;

  // Fixed widths of the item fields
  localparam int unsigned FieldIdxW = 10;
  localparam int unsigned FieldValW = 32;
  localparam int unsigned OpW       = 2;

  // Item operation codes; the remaining code is ignored
  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 2'd0,
    OP_NEAREST = 2'd1,
    OP_BELOW   = 2'd2
  } op_e;

  // Walk sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_UP,
    S_DOWN,
    S_NEAR,
    S_DONE
  } state_e;

endpackage

[rtl/core/nihs_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nihs_table: value table storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------

module nihs_table #(
  parameter int unsigned Depth = nihs_pkg::DefTableDepth,
  parameter int unsigned Width = nihs_pkg::DefValueWidth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Store one entry per write beat
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/nearest_index_hunt_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_index_hunt_search: hunt search over an ascending value table
// Write beats fill the table; search beats walk from a clamped guess to the
// last entry below the target, with an optional step to a closer neighbor.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o  | op, entry_index, entry_value, target,
//          |                          | low_index, high_index, start_guess
//  out     | out_valid_o / out_ready_i| found_index
//
//  A write beat is stored as it is accepted. A search reads one table entry
//  a cycle through the single registered read port: the guess, one entry
//  for each place the walk moves, and the entry above the final position
//  when an upward walk stops below the window top, or when a nearest search
//  that did not walk up checks its upper neighbor.
//  Reset clears the sequencer and the result valid flag; the result index
//  and table contents stay undefined until written.
//  A result waiting in the output register does not block write beats; a
//  following search waits in its final state until that register frees up.
// ----------------------------------------------------------------------------

module nearest_index_hunt_search #(
  parameter int unsigned TABLE_DEPTH = nihs_pkg::DefTableDepth,
  parameter int unsigned VALUE_WIDTH = nihs_pkg::DefValueWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [nihs_pkg::OpW-1:0]             op_i,
  input  logic [nihs_pkg::FieldIdxW-1:0]       entry_index_i,
  input  logic signed [nihs_pkg::FieldValW-1:0] entry_value_i,
  input  logic signed [nihs_pkg::FieldValW-1:0] target_i,
  input  logic [nihs_pkg::FieldIdxW-1:0]       low_index_i,
  input  logic [nihs_pkg::FieldIdxW-1:0]       high_index_i,
  input  logic [nihs_pkg::FieldIdxW-1:0]       start_guess_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [nihs_pkg::FieldIdxW-1:0]       found_index_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned ExtW = (VALUE_WIDTH > nihs_pkg::FieldValW) ?
                                 VALUE_WIDTH : nihs_pkg::FieldValW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  // Saturate a field index into the table range
  function automatic logic [IdxW-1:0] sat_idx(input logic [nihs_pkg::FieldIdxW-1:0] f);
    logic [IdxW-1:0] r;
    if (int'(f) >= int'(TABLE_DEPTH)) begin
      r = LastIdx;
    end else begin
      r = IdxW'(f);
    end
    return r;
  endfunction

  nihs_pkg::state_e state_q, state_d;

  logic [IdxW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        lo_q, lo_d;
  logic [IdxW-1:0]        hi_q, hi_d;
  logic [VALUE_WIDTH-1:0] tgt_q, tgt_d;
  logic [VALUE_WIDTH-1:0] cur_q, cur_d;
  logic                   near_q, near_d;
  logic                   out_valid_q, out_valid_d;
  logic [IdxW-1:0]        found_q, found_d;

  logic                   in_fire;
  logic                   we;
  logic [IdxW-1:0]        waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [IdxW-1:0]        raddr;
  logic [VALUE_WIDTH-1:0] rdata;

  logic [IdxW-1:0]        s_lo, s_hi, s_guess, s_clamp_hi, s_clamp;
  logic [IdxW-1:0]        idx_inc, idx_inc2, idx_dec;
  logic                   rd_below;
  logic signed [VALUE_WIDTH:0] diff_up, diff_down;
  logic                   up_closer;

  nihs_table #(
    .Depth (TABLE_DEPTH),
    .Width (VALUE_WIDTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Decode the incoming beat
  assign in_ready_o = (state_q == nihs_pkg::S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign waddr      = IdxW'(entry_index_i);
  assign wdata      = VALUE_WIDTH'(ExtW'($unsigned(entry_value_i)));

  assign s_lo       = sat_idx(low_index_i);
  assign s_hi       = sat_idx(high_index_i);
  assign s_guess    = sat_idx(start_guess_i);
  assign s_clamp_hi = (s_guess > s_hi) ? s_hi : s_guess;
  assign s_clamp    = (s_clamp_hi < s_lo) ? s_lo : s_clamp_hi;

  // Walk arithmetic on the current position
  assign idx_inc   = idx_q + IdxW'(1);
  assign idx_inc2  = idx_q + IdxW'(2);
  assign idx_dec   = idx_q - IdxW'(1);
  assign rd_below  = $signed(rdata) < $signed(tgt_q);
  assign diff_up   = $signed({rdata[VALUE_WIDTH-1], rdata})
                   - $signed({tgt_q[VALUE_WIDTH-1], tgt_q});
  assign diff_down = $signed({tgt_q[VALUE_WIDTH-1], tgt_q})
                   - $signed({cur_q[VALUE_WIDTH-1], cur_q});
  assign up_closer = diff_up < diff_down;

  // Sequence the walk
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tgt_d       = tgt_q;
    cur_d       = cur_q;
    near_d      = near_q;
    found_d     = found_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    we          = 1'b0;
    raddr       = idx_q;

    unique case (state_q)
      nihs_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (op_i)
            nihs_pkg::OP_WRITE: begin
              we = (int'(entry_index_i) < int'(TABLE_DEPTH));
            end
            nihs_pkg::OP_NEAREST, nihs_pkg::OP_BELOW: begin
              lo_d    = s_lo;
              hi_d    = s_hi;
              idx_d   = s_clamp;
              raddr   = s_clamp;
              tgt_d   = VALUE_WIDTH'(ExtW'($unsigned(target_i)));
              near_d  = (op_i == nihs_pkg::OP_NEAREST);
              state_d = nihs_pkg::S_FIRST;
            end
            default: begin
              // unused code: drop the beat
            end
          endcase
        end
      end

      nihs_pkg::S_FIRST: begin
        cur_d = rdata;
        if (rd_below) begin
          if (idx_q < hi_q) begin
            raddr   = idx_inc;
            state_d = nihs_pkg::S_UP;
          end else begin
            state_d = nihs_pkg::S_DONE;
          end
        end else if (idx_q > lo_q) begin
          idx_d   = idx_dec;
          raddr   = idx_dec;
          state_d = nihs_pkg::S_DOWN;
        end else if (near_q && (idx_q < hi_q)) begin
          raddr   = idx_inc;
          state_d = nihs_pkg::S_NEAR;
        end else begin
          state_d = nihs_pkg::S_DONE;
        end
      end

      nihs_pkg::S_DOWN: begin
        cur_d = rdata;
        if ((idx_q > lo_q) && !rd_below) begin
          idx_d = idx_dec;
          raddr = idx_dec;
        end else if (near_q && (idx_q < hi_q)) begin
          raddr   = idx_inc;
          state_d = nihs_pkg::S_NEAR;
        end else begin
          state_d = nihs_pkg::S_DONE;
        end
      end

      nihs_pkg::S_UP: begin
        // rdata holds the entry above the current position
        if (rd_below) begin
          idx_d = idx_inc;
          cur_d = rdata;
          if (idx_inc < hi_q) begin
            raddr = idx_inc2;
          end else begin
            state_d = nihs_pkg::S_DONE;
          end
        end else begin
          if (near_q && up_closer) begin
            idx_d = idx_inc;
          end
          state_d = nihs_pkg::S_DONE;
        end
      end

      nihs_pkg::S_NEAR: begin
        if (up_closer) begin
          idx_d = idx_inc;
        end
        state_d = nihs_pkg::S_DONE;
      end

      nihs_pkg::S_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          found_d     = idx_q;
          out_valid_d = 1'b1;
          state_d     = nihs_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = nihs_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nihs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    tgt_q   <= tgt_d;
    cur_q   <= cur_d;
    near_q  <= near_d;
    found_q <= found_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_index_o = nihs_pkg::FieldIdxW'(found_q);

endmodule
